// ===== design/tsec_pkg.sv =====
// Shared types and constants for the TTL score entry cache.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package tsec_pkg;

    localparam int ENTRIES    = 16;
    localparam int IDX_W      = 4;
    localparam int SCORE_BITS = 16;
    localparam int CNT_W      = 5;

    localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
    localparam logic [SCORE_BITS-1:0] SCORE_ONE = {{(SCORE_BITS-1){1'b0}}, 1'b1};
    localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(ENTRIES - 1);

    // request kinds
    localparam logic [2:0] K_ADD      = 3'd0;
    localparam logic [2:0] K_FIND     = 3'd1;
    localparam logic [2:0] K_MARK     = 3'd2;
    localparam logic [2:0] K_FLUSH1   = 3'd3;
    localparam logic [2:0] K_FLUSHALL = 3'd4;
    localparam logic [2:0] K_CLEANUP  = 3'd5;
    localparam logic [2:0] K_LOWEST   = 3'd6;
    localparam logic [2:0] K_UNKNOWN  = 3'd7;

    // result kinds
    localparam logic [1:0] RK_FINAL   = 2'd0;
    localparam logic [1:0] RK_FLUSH   = 2'd1;
    localparam logic [1:0] RK_RELEASE = 2'd2;

    // write policies
    localparam logic [1:0] WP_THROUGH  = 2'd1;
    localparam logic [1:0] WP_BACK     = 2'd2;
    localparam logic [1:0] WP_RESERVED = 2'd3;

    // register indexes
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_FLUSH  = 1'b1;

    // one memory row
    typedef struct packed {
        logic [31:0]           tag;
        logic [31:0]           life;
        logic [31:0]           expiry;
        logic [SCORE_BITS-1:0] score;
    } row_t;

endpackage

`default_nettype wire

// ===== design/tsec_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
// No dependencies.
`default_nettype none

interface tsec_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] life_ms;
    logic [31:0] now;

    modport source (output valid, kind, key, life_ms, now, input ready);
    modport sink   (input valid, kind, key, life_ms, now, output ready);
endinterface

`default_nettype wire

// ===== design/tsec_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
// No dependencies.
`default_nettype none

interface tsec_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] entry_key;
    logic [3:0]  slot;
    logic        ok;
    logic [4:0]  flushed_total;
    logic [4:0]  occupancy;
    logic        last;

    modport source (output valid, result_kind, entry_key, slot, ok, flushed_total,
                    occupancy, last, input ready);
    modport sink   (input valid, result_kind, entry_key, slot, ok, flushed_total,
                    occupancy, last, output ready);
endinterface

`default_nettype wire

// ===== design/ttl_score_entry_cache.sv =====
// TTL score entry cache: one request at a time, slots walked in order.
// Each slot visit is a memory read (S_RD), then an update (S_EX); a result
// item holds the walk until the output register is free. An add that evicts
// walks the slots a second time to choose its victim.
// Reset clears valid/dirty bits, count, state, config and the output register; memory and payload registers are not.
`default_nettype none

module ttl_score_entry_cache (
    input  wire logic        clk,
    input  wire logic        rst_n,
    tsec_req_if.sink         req,
    tsec_rsp_if.source       rsp,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [1:0]  cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_EX, S_FIN, S_WR} state_t;

    state_t st_reg, st_next;
    logic [2:0]  op_reg, op_next;
    logic [31:0] key_reg, key_next, life_reg, life_next, now_reg, now_next;
    logic [tsec_pkg::IDX_W-1:0] idx_reg, idx_next, slot_reg, slot_next;
    logic [tsec_pkg::IDX_W-1:0] dslot_reg, dslot_next;
    logic ph_reg, ph_next, stop_reg, stop_next, sset_reg, sset_next;
    logic bset_reg, bset_next, dset_reg, dset_next, hit_reg, hit_next;
    logic evict_reg, evict_next;
    logic [tsec_pkg::SCORE_BITS-1:0] best_reg, best_next;
    logic [31:0] btag_reg, btag_next, dtag_reg, dtag_next;
    logic [tsec_pkg::CNT_W-1:0] total_reg, total_next, count_reg, count_next;
    logic [tsec_pkg::ENTRIES-1:0] valid_reg, valid_next, dirty_reg, dirty_next;
    logic [1:0] pol_reg;
    logic       fen_reg;

    // output register
    logic        ov_reg;
    logic [1:0]  o_kind_reg;
    logic [31:0] o_key_reg;
    logic [3:0]  o_slot_reg;
    logic        o_ok_reg, o_last_reg;
    logic [4:0]  o_total_reg, o_occ_reg;

    // entry memory
    tsec_pkg::row_t mem [tsec_pkg::ENTRIES];
    tsec_pkg::row_t rd_reg, mem_wd;
    logic mem_we;
    logic [tsec_pkg::IDX_W-1:0] mem_wa;

    // item emission
    logic em, can_emit;
    logic [1:0]  e_kind;
    logic [31:0] e_key;
    logic [3:0]  e_slot;
    logic        e_ok, e_last;
    logic [4:0]  e_total, e_occ;

    logic adv, v, d, expired, match, fok, exp_path, add_main, stopped;
    logic [tsec_pkg::SCORE_BITS-1:0] dec;

    assign can_emit = !ov_reg || rsp.ready;
    assign req.ready = (st_reg == S_IDLE);
    assign fok = ((pol_reg == tsec_pkg::WP_THROUGH) || (pol_reg == tsec_pkg::WP_BACK))
                 && fen_reg;
    assign v        = valid_reg[idx_reg];
    assign d        = dirty_reg[idx_reg];
    assign expired  = now_reg >= rd_reg.expiry;
    assign match    = rd_reg.tag == key_reg;
    assign dec      = (rd_reg.score != '0) ? rd_reg.score - 1'b1 : rd_reg.score;
    assign add_main = (op_reg == tsec_pkg::K_ADD) && !evict_reg;
    assign stopped  = add_main && stop_reg;
    assign exp_path = v && expired && !(d && !fok) && !stopped;

    // sequencer
    always_comb
    begin
        st_next = st_reg; op_next = op_reg; key_next = key_reg;
        life_next = life_reg; now_next = now_reg; idx_next = idx_reg;
        slot_next = slot_reg; dslot_next = dslot_reg; ph_next = ph_reg;
        stop_next = stop_reg; sset_next = sset_reg; bset_next = bset_reg;
        dset_next = dset_reg; hit_next = hit_reg; evict_next = evict_reg;
        best_next = best_reg; btag_next = btag_reg; dtag_next = dtag_reg;
        total_next = total_reg; count_next = count_reg;
        valid_next = valid_reg; dirty_next = dirty_reg;
        mem_we = 1'b0; mem_wa = idx_reg; mem_wd = rd_reg;
        em = 1'b0; e_kind = tsec_pkg::RK_FINAL; e_key = '0; e_slot = '0;
        e_ok = 1'b0; e_last = 1'b0; e_total = '0; e_occ = count_reg;
        adv = 1'b0;
        case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.kind; key_next = req.key;
                    life_next = req.life_ms; now_next = req.now;
                    idx_next = '0; ph_next = 1'b0; stop_next = 1'b0;
                    sset_next = 1'b0; bset_next = 1'b0; dset_next = 1'b0;
                    hit_next = 1'b0; evict_next = 1'b0; total_next = '0;
                    slot_next = '0;
                    st_next = (req.kind > tsec_pkg::K_LOWEST) ? S_FIN : S_RD;
                end
            end
            S_RD:
                st_next = S_EX;
            S_EX:
            begin
                if ((add_main || op_reg == tsec_pkg::K_CLEANUP ||
                     op_reg == tsec_pkg::K_FIND) && exp_path)
                begin
                    // expired: flush if dirty, then release
                    em = 1'b1; e_key = rd_reg.tag; e_slot = idx_reg; e_ok = 1'b1;
                    if (d && !ph_reg)
                    begin
                        e_kind = tsec_pkg::RK_FLUSH;
                        if (can_emit)
                        begin
                            dirty_next[idx_reg] = 1'b0;
                            ph_next = 1'b1;
                        end
                    end
                    else
                    begin
                        e_kind = tsec_pkg::RK_RELEASE;
                        e_occ = count_reg - 1'b1;
                        if (can_emit)
                        begin
                            valid_next[idx_reg] = 1'b0;
                            dirty_next[idx_reg] = 1'b0;
                            count_next = count_reg - 1'b1;
                            ph_next = 1'b0;
                            adv = 1'b1;
                            if (add_main && !sset_reg)
                            begin
                                sset_next = 1'b1;
                                slot_next = idx_reg;
                            end
                        end
                    end
                end
                else
                begin
                    case (op_reg)
                        tsec_pkg::K_ADD, tsec_pkg::K_CLEANUP, tsec_pkg::K_LOWEST:
                        begin
                            if (op_reg == tsec_pkg::K_LOWEST || evict_reg)
                            begin
                                // lowest score scan
                                if (v && (op_reg == tsec_pkg::K_LOWEST || !d) &&
                                    (!bset_reg || rd_reg.score < best_reg))
                                begin
                                    bset_next = 1'b1; best_next = rd_reg.score;
                                    btag_next = rd_reg.tag; slot_next = idx_reg;
                                end
                                if (evict_reg && v && d && !dset_reg)
                                begin
                                    dset_next = 1'b1; dslot_next = idx_reg;
                                    dtag_next = rd_reg.tag;
                                end
                            end
                            else if (v)
                            begin
                                // decay, renew an expired entry kept dirty
                                mem_we = 1'b1;
                                mem_wd.score = dec;
                                if (expired && !stopped)
                                    mem_wd.expiry = now_reg + rd_reg.life;
                            end
                            else if (add_main && !stop_reg)
                            begin
                                stop_next = 1'b1; sset_next = 1'b1;
                                slot_next = idx_reg;
                            end
                            adv = 1'b1;
                        end
                        tsec_pkg::K_FIND:
                        begin
                            if (!v)
                                adv = 1'b1;
                            else
                            begin
                                mem_we = 1'b1;
                                if (expired)
                                    mem_wd.expiry = now_reg + rd_reg.life;
                                if (match)
                                begin
                                    if (rd_reg.score != tsec_pkg::SCORE_MAX)
                                        mem_wd.score = rd_reg.score + 1'b1;
                                    mem_wd.expiry = now_reg + rd_reg.life;
                                    em = 1'b1; e_key = key_reg; e_slot = idx_reg;
                                    e_ok = 1'b1; e_last = 1'b1;
                                    if (can_emit)
                                        st_next = S_IDLE;
                                end
                                else
                                begin
                                    mem_wd.score = dec;
                                    adv = 1'b1;
                                end
                            end
                        end
                        tsec_pkg::K_MARK, tsec_pkg::K_FLUSH1:
                        begin
                            if (v && match)
                            begin
                                hit_next = 1'b1; slot_next = idx_reg; st_next = S_FIN;
                            end
                            else
                                adv = 1'b1;
                        end
                        tsec_pkg::K_FLUSHALL:
                        begin
                            if (v && d && fok)
                            begin
                                em = 1'b1; e_kind = tsec_pkg::RK_FLUSH;
                                e_key = rd_reg.tag; e_slot = idx_reg; e_ok = 1'b1;
                                if (can_emit)
                                begin
                                    dirty_next[idx_reg] = 1'b0;
                                    total_next = total_reg + 1'b1;
                                    adv = 1'b1;
                                end
                            end
                            else
                                adv = 1'b1;
                        end
                        default:
                            adv = 1'b1;
                    endcase
                end
                if (adv)
                begin
                    if (idx_reg == tsec_pkg::IDX_LAST)
                        st_next = S_FIN;
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                        st_next = S_RD;
                    end
                end
            end
            S_FIN:
            begin
                em = 1'b1; e_last = 1'b1;
                case (op_reg)
                    tsec_pkg::K_ADD:
                    begin
                        if (!evict_reg)
                        begin
                            em = 1'b0;
                            if (sset_reg)
                                st_next = S_WR;
                            else
                            begin
                                evict_next = 1'b1; idx_next = '0; st_next = S_RD;
                            end
                        end
                        else if (bset_reg || (dset_reg && fok && ph_reg))
                        begin
                            // release the victim
                            e_last = 1'b0; e_kind = tsec_pkg::RK_RELEASE; e_ok = 1'b1;
                            e_key = bset_reg ? btag_reg : dtag_reg;
                            e_slot = bset_reg ? slot_reg : dslot_reg;
                            e_occ = count_reg - 1'b1;
                            if (can_emit)
                            begin
                                valid_next[e_slot] = 1'b0;
                                dirty_next[e_slot] = 1'b0;
                                count_next = count_reg - 1'b1;
                                slot_next = e_slot;
                                st_next = S_WR;
                            end
                        end
                        else if (dset_reg && fok)
                        begin
                            e_last = 1'b0; e_kind = tsec_pkg::RK_FLUSH; e_ok = 1'b1;
                            e_key = dtag_reg; e_slot = dslot_reg;
                            if (can_emit)
                            begin
                                dirty_next[dslot_reg] = 1'b0;
                                ph_next = 1'b1;
                            end
                        end
                        else
                        begin
                            e_key = key_reg;
                            if (can_emit)
                                st_next = S_IDLE;
                        end
                    end
                    tsec_pkg::K_MARK:
                    begin
                        if (hit_reg)
                        begin
                            e_key = key_reg; e_slot = slot_reg;
                        end
                        if (!hit_reg ||
                            !(pol_reg == tsec_pkg::WP_THROUGH || pol_reg == tsec_pkg::WP_BACK))
                        begin
                            if (can_emit)
                                st_next = S_IDLE;
                        end
                        else if (pol_reg == tsec_pkg::WP_THROUGH && fok && !ph_reg)
                        begin
                            e_kind = tsec_pkg::RK_FLUSH; e_ok = 1'b1; e_last = 1'b0;
                            if (can_emit)
                            begin
                                dirty_next[slot_reg] = 1'b0;
                                ph_next = 1'b1;
                            end
                        end
                        else
                        begin
                            e_ok = (pol_reg == tsec_pkg::WP_BACK) || ph_reg;
                            if (can_emit)
                            begin
                                if (!ph_reg)
                                    dirty_next[slot_reg] = 1'b1;
                                st_next = S_IDLE;
                            end
                        end
                    end
                    tsec_pkg::K_FLUSH1:
                    begin
                        if (hit_reg)
                        begin
                            e_key = key_reg; e_slot = slot_reg;
                            e_ok = !dirty_reg[slot_reg];
                        end
                        if (hit_reg && dirty_reg[slot_reg] && fok)
                        begin
                            e_kind = tsec_pkg::RK_FLUSH; e_ok = 1'b1; e_last = 1'b0;
                            if (can_emit)
                                dirty_next[slot_reg] = 1'b0;
                        end
                        else if (can_emit)
                            st_next = S_IDLE;
                    end
                    tsec_pkg::K_FLUSHALL, tsec_pkg::K_CLEANUP:
                    begin
                        e_ok = 1'b1; e_total = total_reg;
                        if (can_emit)
                            st_next = S_IDLE;
                    end
                    tsec_pkg::K_LOWEST:
                    begin
                        if (bset_reg)
                        begin
                            e_ok = 1'b1; e_key = btag_reg; e_slot = slot_reg;
                        end
                        if (can_emit)
                            st_next = S_IDLE;
                    end
                    default:
                    begin
                        if (can_emit)
                            st_next = S_IDLE;
                    end
                endcase
            end
            S_WR:
            begin
                // install the new entry
                em = 1'b1; e_key = key_reg; e_slot = slot_reg; e_ok = 1'b1;
                e_last = 1'b1; e_occ = count_reg + 1'b1;
                if (can_emit)
                begin
                    mem_we = 1'b1; mem_wa = slot_reg;
                    mem_wd.tag = key_reg; mem_wd.life = life_reg;
                    mem_wd.expiry = now_reg + life_reg;
                    mem_wd.score = tsec_pkg::SCORE_ONE;
                    valid_next[slot_reg] = 1'b1;
                    dirty_next[slot_reg] = 1'b0;
                    count_next = count_reg + 1'b1;
                    st_next = S_IDLE;
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (st_reg == S_RD)
            rd_reg <= mem[idx_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg <= op_next; key_reg <= key_next; life_reg <= life_next;
        now_reg <= now_next; idx_reg <= idx_next; slot_reg <= slot_next;
        dslot_reg <= dslot_next; best_reg <= best_next; btag_reg <= btag_next;
        dtag_reg <= dtag_next;
    end

    // control state, output register and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_IDLE; ph_reg <= 1'b0; stop_reg <= 1'b0; sset_reg <= 1'b0;
            bset_reg <= 1'b0; dset_reg <= 1'b0; hit_reg <= 1'b0; evict_reg <= 1'b0;
            total_reg <= '0; count_reg <= '0; valid_reg <= '0; dirty_reg <= '0;
            pol_reg <= '0; fen_reg <= 1'b0; ov_reg <= 1'b0;
            o_kind_reg <= '0; o_key_reg <= '0; o_slot_reg <= '0; o_ok_reg <= 1'b0;
            o_total_reg <= '0; o_occ_reg <= '0; o_last_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; ph_reg <= ph_next; stop_reg <= stop_next;
            sset_reg <= sset_next; bset_reg <= bset_next; dset_reg <= dset_next;
            hit_reg <= hit_next; evict_reg <= evict_next; total_reg <= total_next;
            count_reg <= count_next; valid_reg <= valid_next; dirty_reg <= dirty_next;
            if (em && can_emit)
            begin
                ov_reg <= 1'b1;
                o_kind_reg <= e_kind; o_key_reg <= e_key; o_slot_reg <= e_slot;
                o_ok_reg <= e_ok; o_total_reg <= e_total; o_occ_reg <= e_occ;
                o_last_reg <= e_last;
            end
            else if (rsp.ready)
                ov_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == tsec_pkg::CFG_POLICY)
                    pol_reg <= cfg_data;
                else if (cfg_index == tsec_pkg::CFG_FLUSH)
                    fen_reg <= cfg_data[0];
            end
        end
    end

    assign rsp.valid         = ov_reg;
    assign rsp.result_kind   = o_kind_reg;
    assign rsp.entry_key     = o_key_reg;
    assign rsp.slot          = o_slot_reg;
    assign rsp.ok            = o_ok_reg;
    assign rsp.flushed_total = o_total_reg;
    assign rsp.occupancy     = o_occ_reg;
    assign rsp.last          = o_last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/tb_ttl_score_entry_cache.sv =====
// Self-checking testbench for the TTL score entry cache: drives requests through the
// request interface, predicts every result item and checks it field by field.
// Depends on tsec_pkg, tsec_req_if, tsec_rsp_if and ttl_score_entry_cache.
`timescale 1ns / 1ps

module tb_ttl_score_entry_cache;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] key;
        logic [31:0] life_ms;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [31:0] entry_key;
        logic [3:0]  slot;
        logic        ok;
        logic [4:0]  flushed_total;
        logic [4:0]  occupancy;
        logic        last;
    } res_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [1:0] cfg_data;

    tsec_req_if req ();
    tsec_rsp_if rsp ();

    ttl_score_entry_cache DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.sink),
        .rsp       (rsp.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the table
    logic                            sh_valid [tsec_pkg::ENTRIES];
    logic                            sh_dirty [tsec_pkg::ENTRIES];
    logic [31:0]                     sh_tag   [tsec_pkg::ENTRIES];
    logic [31:0]                     sh_life  [tsec_pkg::ENTRIES];
    logic [31:0]                     sh_exp   [tsec_pkg::ENTRIES];
    logic [tsec_pkg::SCORE_BITS-1:0] sh_score [tsec_pkg::ENTRIES];
    logic [4:0]            sh_count;
    logic [1:0]            sh_policy;
    logic                  sh_flush_en;

    req_t pending_reqs[$];
    res_t expected_results[$];
    int   errors;
    int   send_idle_pct;
    int   recv_idle_pct;
    bit   hold_req;
    bit   hold_on;
    bit   stim_done;
    logic [31:0] key_pool[8];
    logic [31:0] clock_ms;

    task automatic report(input string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    function automatic void push_result(input logic [1:0] rk, input logic [31:0] k,
                                        input int s, input logic ok,
                                        input logic [4:0] tot, input logic last);
        res_t r;
        r.result_kind = rk;
        r.entry_key = k;
        r.slot = 4'(s);
        r.ok = ok;
        r.flushed_total = tot;
        r.occupancy = sh_count;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic bit can_flush();
        return (sh_policy == tsec_pkg::WP_THROUGH || sh_policy == tsec_pkg::WP_BACK)
               && sh_flush_en;
    endfunction

    function automatic bit flush_entry(input int i);
        if (!sh_valid[i])
            return 0;
        if (!sh_dirty[i])
            return 1;
        if (!can_flush())
            return 0;
        sh_dirty[i] = 0;
        push_result(tsec_pkg::RK_FLUSH, sh_tag[i], i, 1, 0, 0);
        return 1;
    endfunction

    function automatic bit release_entry(input int i, input bit flush_first);
        if (!sh_valid[i])
            return 1;
        if (flush_first && sh_dirty[i] && !flush_entry(i))
            return 0;
        sh_valid[i] = 0;
        sh_dirty[i] = 0;
        if (sh_count > 0)
            sh_count--;
        push_result(tsec_pkg::RK_RELEASE, sh_tag[i], i, 1, 0, 0);
        return 1;
    endfunction

    function automatic void decay_scores();
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
            if (sh_valid[i] && sh_score[i] > 0)
                sh_score[i]--;
    endfunction

    function automatic bit evict_entry();
        int best;
        best = -1;
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
        begin
            if (!sh_valid[i] || sh_dirty[i])
                continue;
            if (best < 0 || sh_score[i] < sh_score[best])
                best = i;
        end
        if (best >= 0)
            return release_entry(best, 0);
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
        begin
            if (!sh_valid[i] || !sh_dirty[i])
                continue;
            if (flush_entry(i))
                return release_entry(i, 0);
        end
        return 0;
    endfunction

    function automatic int find_key(input logic [31:0] k);
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
            if (sh_valid[i] && sh_tag[i] == k)
                return i;
        return -1;
    endfunction

    // works out every result item caused by one request
    function automatic void predict_request(input req_t q);
        int s;
        bit r;
        logic [4:0] total;
        s = -1;
        case (q.kind)
            tsec_pkg::K_ADD:
            begin
                decay_scores();
                for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                begin
                    if (!sh_valid[i])
                    begin
                        s = i;
                        break;
                    end
                    if (q.now >= sh_exp[i])
                    begin
                        if (release_entry(i, 1))
                        begin
                            if (s < 0)
                                s = i;
                        end
                        else
                            sh_exp[i] = q.now + sh_life[i];
                    end
                end
                if (s < 0)
                begin
                    if (!evict_entry())
                    begin
                        push_result(tsec_pkg::RK_FINAL, q.key, 0, 0, 0, 1);
                        return;
                    end
                    for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                        if (!sh_valid[i])
                        begin
                            s = i;
                            break;
                        end
                end
                if (s < 0)
                begin
                    push_result(tsec_pkg::RK_FINAL, q.key, 0, 0, 0, 1);
                    return;
                end
                sh_tag[s] = q.key;
                sh_life[s] = q.life_ms;
                sh_exp[s] = q.now + q.life_ms;
                sh_score[s] = tsec_pkg::SCORE_ONE;
                sh_dirty[s] = 0;
                sh_valid[s] = 1;
                sh_count++;
                push_result(tsec_pkg::RK_FINAL, q.key, s, 1, 0, 1);
            end
            tsec_pkg::K_FIND:
            begin
                for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                begin
                    if (!sh_valid[i])
                        continue;
                    if (q.now >= sh_exp[i])
                    begin
                        if (release_entry(i, 1))
                            continue;
                        sh_exp[i] = q.now + sh_life[i];
                    end
                    if (sh_tag[i] == q.key)
                    begin
                        if (sh_score[i] < tsec_pkg::SCORE_MAX)
                            sh_score[i]++;
                        sh_exp[i] = q.now + sh_life[i];
                        push_result(tsec_pkg::RK_FINAL, q.key, i, 1, 0, 1);
                        return;
                    end
                    if (sh_score[i] > 0)
                        sh_score[i]--;
                end
                push_result(tsec_pkg::RK_FINAL, 0, 0, 0, 0, 1);
            end
            tsec_pkg::K_MARK:
            begin
                s = find_key(q.key);
                if (s < 0)
                    push_result(tsec_pkg::RK_FINAL, 0, 0, 0, 0, 1);
                else if (sh_policy != tsec_pkg::WP_THROUGH && sh_policy != tsec_pkg::WP_BACK)
                    push_result(tsec_pkg::RK_FINAL, q.key, s, 0, 0, 1);
                else
                begin
                    sh_dirty[s] = 1;
                    r = 1;
                    if (sh_policy == tsec_pkg::WP_THROUGH)
                        r = flush_entry(s);
                    push_result(tsec_pkg::RK_FINAL, q.key, s, r, 0, 1);
                end
            end
            tsec_pkg::K_FLUSH1:
            begin
                s = find_key(q.key);
                if (s < 0)
                    push_result(tsec_pkg::RK_FINAL, 0, 0, 0, 0, 1);
                else
                begin
                    r = flush_entry(s);
                    push_result(tsec_pkg::RK_FINAL, q.key, s, r, 0, 1);
                end
            end
            tsec_pkg::K_FLUSHALL:
            begin
                total = 0;
                for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                    if (sh_valid[i] && sh_dirty[i] && flush_entry(i))
                        total++;
                push_result(tsec_pkg::RK_FINAL, 0, 0, 1, total, 1);
            end
            tsec_pkg::K_CLEANUP:
            begin
                decay_scores();
                for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                    if (sh_valid[i] && q.now >= sh_exp[i])
                        if (!release_entry(i, 1))
                            sh_exp[i] = q.now + sh_life[i];
                push_result(tsec_pkg::RK_FINAL, 0, 0, 1, 0, 1);
            end
            tsec_pkg::K_LOWEST:
            begin
                for (int i = 0; i < tsec_pkg::ENTRIES; i++)
                begin
                    if (!sh_valid[i])
                        continue;
                    if (s < 0 || sh_score[i] < sh_score[s])
                        s = i;
                end
                if (s < 0)
                    push_result(tsec_pkg::RK_FINAL, 0, 0, 0, 0, 1);
                else
                    push_result(tsec_pkg::RK_FINAL, sh_tag[s], s, 1, 0, 1);
            end
            default:
                push_result(tsec_pkg::RK_FINAL, 0, 0, 0, 0, 1);
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 0;
            req.kind <= '0;
            req.key <= '0;
            req.life_ms <= '0;
            req.now <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
                predict_request({req.kind, req.key, req.life_ms, req.now});
            if (!req.valid || req.ready)
            begin
                if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req_t q;
                    q = pending_reqs.pop_front();
                    req.valid <= 1;
                    req.kind <= q.kind;
                    req.key <= q.key;
                    req.life_ms <= q.life_ms;
                    req.now <= q.now;
                end
                else
                    req.valid <= 0;
            end
        end
    end

    // long receiver hold, counted in cycles
    initial
    begin
        hold_on = 0;
        wait (hold_req);
        hold_on = 1;
        repeat (600) @(posedge clk);
        hold_on = 0;
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_results.size() == 0)
                    report($sformatf("unexpected item %p", rsp.result_kind));
                else
                begin
                    res_t e;
                    e = expected_results.pop_front();
                    if (rsp.result_kind !== e.result_kind)
                        report($sformatf("result_kind %0d want %0d", rsp.result_kind,
                                         e.result_kind));
                    if (rsp.entry_key !== e.entry_key)
                        report($sformatf("entry_key %h want %h", rsp.entry_key,
                                         e.entry_key));
                    if (rsp.slot !== e.slot)
                        report($sformatf("slot %0d want %0d", rsp.slot, e.slot));
                    if (rsp.ok !== e.ok)
                        report($sformatf("ok %b want %b", rsp.ok, e.ok));
                    if (rsp.flushed_total !== e.flushed_total)
                        report($sformatf("flushed_total %0d want %0d", rsp.flushed_total,
                                         e.flushed_total));
                    if (rsp.occupancy !== e.occupancy)
                        report($sformatf("occupancy %0d want %0d", rsp.occupancy,
                                         e.occupancy));
                    if (rsp.last !== e.last)
                        report($sformatf("last %b want %b", rsp.last, e.last));
                end
            end
            if (hold_on)
                rsp.ready <= 0;
            else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic queue_req(input logic [2:0] k, input logic [31:0] key,
                             input logic [31:0] life, input logic [31:0] now);
        pending_reqs.push_back({k, key, life, now});
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        @(posedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == tsec_pkg::CFG_POLICY)
            sh_policy = val;
        else
            sh_flush_en = val[0];
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // lets the block go idle before a register write
    task automatic drain();
        while (pending_reqs.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (4 * tsec_pkg::ENTRIES + 10) @(posedge clk);
    endtask

    // random request, mostly on a small set of keys with plausible times
    task automatic queue_random();
        int pick;
        logic [31:0] key;
        logic [31:0] life;
        pick = $urandom_range(99);
        clock_ms = clock_ms + $urandom_range(40);
        key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
        life = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(200);
        if (pick < 30)
            queue_req(tsec_pkg::K_ADD, key, life, clock_ms);
        else if (pick < 50)
            queue_req(tsec_pkg::K_FIND, key, 0, clock_ms);
        else if (pick < 63)
            queue_req(tsec_pkg::K_MARK, key, $urandom(), clock_ms);
        else if (pick < 73)
            queue_req(tsec_pkg::K_FLUSH1, key, 0, clock_ms);
        else if (pick < 80)
            queue_req(tsec_pkg::K_FLUSHALL, $urandom(), $urandom(), clock_ms);
        else if (pick < 88)
            queue_req(tsec_pkg::K_CLEANUP, $urandom(), 0, clock_ms);
        else if (pick < 97)
            queue_req(tsec_pkg::K_LOWEST, 0, 0, clock_ms);
        else if (pick < 99)
            queue_req(tsec_pkg::K_UNKNOWN, $urandom(), $urandom(), $urandom());
        else
            queue_req(3'($urandom_range(6)), $urandom(), $urandom(), $urandom());
    endtask

    // stimulus
    initial
    begin
        errors = 0;
        stim_done = 0;
        hold_req = 0;
        clock_ms = 1000;
        send_idle_pct = 29;
        recv_idle_pct = 79;
        sh_count = 0;
        sh_policy = 0;
        sh_flush_en = 0;
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
        begin
            sh_valid[i] = 0;
            sh_dirty[i] = 0;
        end
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        rst_n = 0;
        cfg_we = 0;
        cfg_index = tsec_pkg::CFG_POLICY;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;

        // directed: empty table, read only, extremes of the fields
        queue_req(tsec_pkg::K_LOWEST, 0, 0, 0);
        queue_req(tsec_pkg::K_FIND, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        queue_req(tsec_pkg::K_ADD, 32'h0, 32'hFFFF_FFFF, 32'h0);
        queue_req(tsec_pkg::K_ADD, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        queue_req(tsec_pkg::K_ADD, 32'h0, 32'd10, 32'd5);
        queue_req(tsec_pkg::K_MARK, 32'h0, 0, 32'd6);
        queue_req(tsec_pkg::K_FLUSH1, 32'h0, 0, 32'd6);
        queue_req(tsec_pkg::K_FLUSH1, 32'h1234, 0, 32'd6);
        queue_req(tsec_pkg::K_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(tsec_pkg::K_FIND, 32'h0, 0, 32'd7);
        queue_req(tsec_pkg::K_LOWEST, 0, 0, 32'd7);
        queue_req(tsec_pkg::K_CLEANUP, 0, 0, 32'hFFFF_FFFF);
        drain();

        // write back with flush path off: dirty expiry renews, eviction fails when all dirty
        write_reg(tsec_pkg::CFG_POLICY, tsec_pkg::WP_BACK);
        for (int i = 0; i < tsec_pkg::ENTRIES; i++)
        begin
            queue_req(tsec_pkg::K_ADD, 32'h100 + i, 32'd50, 32'd100);
            queue_req(tsec_pkg::K_MARK, 32'h100 + i, 0, 32'd100);
        end
        queue_req(tsec_pkg::K_ADD, 32'h200, 32'd50, 32'd110);
        queue_req(tsec_pkg::K_CLEANUP, 0, 0, 32'd200);
        queue_req(tsec_pkg::K_FLUSHALL, 0, 0, 32'd200);
        drain();

        // flush path on: flush all, then expiry with flush-then-release
        write_reg(tsec_pkg::CFG_FLUSH, 2'd1);
        queue_req(tsec_pkg::K_FLUSH1, 32'h100, 0, 32'd210);
        queue_req(tsec_pkg::K_FLUSHALL, 0, 0, 32'd210);
        for (int i = 0; i < 4; i++)
            queue_req(tsec_pkg::K_MARK, 32'h104 + i, 0, 32'd210);
        queue_req(tsec_pkg::K_ADD, 32'h300, 32'd5, 32'd400);
        queue_req(tsec_pkg::K_ADD, 32'h301, 32'd5, 32'd400);
        drain();

        // write through, then random mix; a long receiver hold fills the block
        write_reg(tsec_pkg::CFG_POLICY, tsec_pkg::WP_THROUGH);
        clock_ms = 500;
        for (int i = 0; i < 30; i++)
            queue_random();
        hold_req = 1;
        drain();
        write_reg(tsec_pkg::CFG_POLICY, tsec_pkg::WP_RESERVED);
        write_reg(tsec_pkg::CFG_FLUSH, 2'd0);
        send_idle_pct = 79;
        recv_idle_pct = 29;
        for (int i = 0; i < 30; i++)
            queue_random();
        drain();
        write_reg(tsec_pkg::CFG_POLICY, tsec_pkg::WP_BACK);
        write_reg(tsec_pkg::CFG_FLUSH, 2'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 35; i++)
            queue_random();
        drain();
        stim_done = 1;
    end

    // end of run
    initial
    begin
        wait (stim_done);
        if (errors == 0)
            $display("tb_ttl_score_entry_cache: PASS");
        else
            $display("tb_ttl_score_entry_cache: FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb_ttl_score_entry_cache: FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
design/tsec_pkg.sv
design/tsec_req_if.sv
design/tsec_rsp_if.sv
design/ttl_score_entry_cache.sv
tb/sv/tb_ttl_score_entry_cache.sv
